// ===== rtl/core/cot_pkg.sv =====
// ----------------------------------------------------------------------------
// cot_pkg: shared types and constants of the centroid object tracker
// beat layouts, result kinds, register indexes, reset values, control structs
// ----------------------------------------------------------------------------
package cot_pkg;

	localparam int TABLE_SLOTS_DEF = 16;

	localparam int POS_W   = 12;
	localparam int AREA_W  = 20;
	localparam int TIME_W  = 32;
	localparam int RAD_W   = 12;
	localparam int AGE_W   = 16;
	localparam int SLOT_W  = 4;
	localparam int RM_W    = 5;
	localparam int NET_W   = 16;
	localparam int OFS_W   = 16;
	localparam int SQ_W    = 2 * POS_W;

	// input beat: pos_x, pos_y, area, now from the lowest bit up
	localparam int IN_TDATA_W  = 80;
	localparam int IN_X_LSB    = 0;
	localparam int IN_Y_LSB    = 12;
	localparam int IN_AREA_LSB = 24;
	localparam int IN_NOW_LSB  = 44;

	// output beat: slot, object_id, removed_count, net_count from the lowest bit up
	localparam int OUT_TDATA_W = 64;
	localparam int OUT_ID_LSB  = 4;
	localparam int OUT_RM_LSB  = 36;
	localparam int OUT_NET_LSB = 41;
	localparam int OUT_USED_W  = 57;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MATCH_RADIUS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STALE_AGE    = CFG_IDX_W'(1);

	localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(30);
	localparam logic [AGE_W-1:0] AGE_RST    = AGE_W'(40);
	localparam logic [OFS_W-1:0] OFS_RST    = OFS_W'(1);

	localparam logic signed [NET_W-1:0] NET_MAX = 16'sh7fff;
	localparam logic signed [NET_W-1:0] NET_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		KIND_MATCH = 2'd0,
		KIND_ADD   = 2'd1,
		KIND_DROP  = 2'd2,
		KIND_FRAME = 2'd3
	} kind_t;

	typedef enum logic {
		OP_REGION = 1'b0,
		OP_SWEEP  = 1'b1
	} op_t;

	// one table entry besides its id
	typedef struct packed {
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [AREA_W-1:0] area;
		logic [TIME_W-1:0] last_seen;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic issue;
		logic issue_last;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/core/centroid_object_tracker_core.sv =====
// ----------------------------------------------------------------------------
// centroid_object_tracker_core: nearest-centroid object tracking table
// matches detected regions to tracked objects and ages them out per frame
// ----------------------------------------------------------------------------
// usage
//  - s_axis carries one item per beat: tuser = op (region or end of frame),
//    tdata = pos_x, pos_y, area, now
//  - m_axis returns exactly one result beat per item: tuser = kind,
//    tdata = slot, object_id, removed_count, net_count
//  - cfg writes match_radius (index 0) or stale_age (index 1); other indexes
//    are ignored; write only while no item is in flight, cfg_ready is always high
//  - each item scans every slot, one slot address per cycle through the table
//    memory read port, then a 3-stage compare pipeline drains and a commit
//    step updates the table and loads the result beat; a new item is taken
//    only after the previous one has committed
//  - s_axis_tready is high only while the block waits for an item
//  - the result sits in an output register; the next item is taken and
//    scanned while it waits, and only its commit holds until the beat is taken
//  - reset frees all slots at once (occupancy flops), loads the register
//    defaults and the per-frame counters; no clearing pass is needed
// ----------------------------------------------------------------------------
module centroid_object_tracker_core #(
	parameter int TABLE_SLOTS = cot_pkg::TABLE_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// item channel
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [cot_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // pos_x, pos_y, area, now, pad
	input  logic                               s_axis_tuser,  // op
	// result channel
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [cot_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // slot, object_id, removed_count,
	                                                          // net_count, pad
	output logic [1:0]                         m_axis_tuser,  // kind
	// register write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cot_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cot_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

	cot_pkg::cmd_t    cmd;
	cot_pkg::status_t status;
	logic [IDX_W-1:0] issue_idx;

	// register writes are always taken at once
	assign cfg_ready = 1'b1;

	cot_ctrl #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd),
		.issue_idx(issue_idx)
	);

	cot_dp #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_op    (s_axis_tuser),
		.in_data  (s_axis_tdata),
		.cmd      (cmd),
		.issue_idx(issue_idx),
		.status   (status),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_kind (m_axis_tuser)
	);

endmodule

// ===== rtl/core/cot_ctrl.sv =====
// ----------------------------------------------------------------------------
// cot_ctrl: sequencer of the tracker
// takes an item, walks the slot addresses, waits for the scan to drain, commits
// ----------------------------------------------------------------------------
module cot_ctrl #(
	parameter int TABLE_SLOTS = cot_pkg::TABLE_SLOTS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  cot_pkg::status_t                              status,
	output cot_pkg::cmd_t                                 cmd,
	output logic [((TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1)-1:0] issue_idx
);

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (status.scan_done) state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready       = (state_q == ST_IDLE);
	assign issue_idx      = idx_q;
	assign cmd.load       = (state_q == ST_IDLE) && in_valid;
	assign cmd.issue      = (state_q == ST_SCAN);
	assign cmd.issue_last = (idx_q == LAST_IDX);
	assign cmd.commit     = (state_q == ST_COMMIT) && status.out_free;

endmodule

// ===== rtl/core/cot_dp.sv =====
// ----------------------------------------------------------------------------
// cot_dp: datapath of the tracker
// slot table memories, scan pipeline, frame counters, output register
// ----------------------------------------------------------------------------
module cot_dp #(
	parameter int TABLE_SLOTS = cot_pkg::TABLE_SLOTS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_valid,
	input  logic [cot_pkg::CFG_IDX_W-1:0]                 cfg_index,
	input  logic [cot_pkg::CFG_DATA_W-1:0]                cfg_data,
	input  logic                                          in_op,
	input  logic [cot_pkg::IN_TDATA_W-1:0]                in_data,
	input  cot_pkg::cmd_t                                 cmd,
	input  logic [((TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1)-1:0] issue_idx,
	output cot_pkg::status_t                              status,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic [cot_pkg::OUT_TDATA_W-1:0]               out_data,
	output logic [1:0]                                    out_kind
);

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int POS_W = cot_pkg::POS_W;
	localparam int SQ_W  = cot_pkg::SQ_W;
	localparam int TW    = cot_pkg::TIME_W;

	// configuration
	logic [cot_pkg::RAD_W-1:0] radius_q;
	logic [cot_pkg::AGE_W-1:0] age_q;
	logic [SQ_W-1:0]           r2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= cot_pkg::RADIUS_RST;
			age_q    <= cot_pkg::AGE_RST;
		end else if (cfg_valid) begin
			if (cfg_index == cot_pkg::REG_MATCH_RADIUS)
				radius_q <= cfg_data[cot_pkg::RAD_W-1:0];
			else if (cfg_index == cot_pkg::REG_STALE_AGE)
				age_q <= cfg_data[cot_pkg::AGE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		r2_q <= SQ_W'(radius_q) * SQ_W'(radius_q);
	end

	// item registers
	logic                       op_q;
	logic [POS_W-1:0]           px_q;
	logic [POS_W-1:0]           py_q;
	logic [cot_pkg::AREA_W-1:0] area_q;
	logic [TW-1:0]              now_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_op;
			px_q   <= in_data[cot_pkg::IN_X_LSB +: POS_W];
			py_q   <= in_data[cot_pkg::IN_Y_LSB +: POS_W];
			area_q <= in_data[cot_pkg::IN_AREA_LSB +: cot_pkg::AREA_W];
			now_q  <= in_data[cot_pkg::IN_NOW_LSB +: TW];
		end
	end

	// slot table
	cot_pkg::entry_t mem_ent [TABLE_SLOTS];
	logic [TW-1:0]   mem_id  [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] occ_q;

	logic            wr_ent;
	logic            wr_id;
	logic [IDX_W-1:0] wr_idx;
	cot_pkg::entry_t wr_data;
	logic [TW-1:0]   nid;

	// scan pipeline
	logic            tok_s1, tok_s2, tok_s3;
	logic            last_s1, last_s2, last_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic            occ_s1, occ_s2, occ_s3;
	cot_pkg::entry_t ent_s1;
	logic [TW-1:0]   id_s1, id_s2, id_s3;
	logic [POS_W-1:0] dx_s2, dy_s2;
	logic            stale_s2, stale_s3;
	logic [SQ_W-1:0] sqx_s3, sqy_s3;

	always_ff @(posedge clk) begin
		if (wr_ent) mem_ent[wr_idx] <= wr_data;
		if (wr_id)  mem_id[wr_idx]  <= nid;
		ent_s1 <= mem_ent[issue_idx];
		id_s1  <= mem_id[issue_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1  <= 1'b0;
			tok_s2  <= 1'b0;
			tok_s3  <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			tok_s1  <= cmd.issue;
			tok_s2  <= tok_s1;
			tok_s3  <= tok_s2;
			last_s1 <= cmd.issue && cmd.issue_last;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= issue_idx;
		occ_s1   <= occ_q[issue_idx];
		idx_s2   <= idx_s1;
		occ_s2   <= occ_s1;
		id_s2    <= id_s1;
		dx_s2    <= (ent_s1.x > px_q) ? (ent_s1.x - px_q) : (px_q - ent_s1.x);
		dy_s2    <= (ent_s1.y > py_q) ? (ent_s1.y - py_q) : (py_q - ent_s1.y);
		stale_s2 <= ((ent_s1.last_seen + TW'(age_q)) < now_q);
		idx_s3   <= idx_s2;
		occ_s3   <= occ_s2;
		id_s3    <= id_s2;
		stale_s3 <= stale_s2;
		sqx_s3   <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3   <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
	end

	logic near_s3;
	logic remove_s3;
	assign near_s3   = ({1'b0, sqx_s3} + {1'b0, sqy_s3}) < {1'b0, r2_q};
	assign remove_s3 = tok_s3 && (op_q == cot_pkg::OP_SWEEP) && occ_s3 && stale_s3;

	// first match and first free slot in scan order
	logic             found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [TW-1:0]    match_id_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [cot_pkg::RM_W-1:0] removed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			removed_q <= '0;
		end else if (cmd.load) begin
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			removed_q <= '0;
		end else if (tok_s3) begin
			if (op_q == cot_pkg::OP_REGION) begin
				if (!found_q && occ_s3 && near_s3) found_q <= 1'b1;
				if (!free_q && !occ_s3) free_q <= 1'b1;
			end else if (remove_s3 && (removed_q != '1)) begin
				removed_q <= removed_q + cot_pkg::RM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_s3 && (op_q == cot_pkg::OP_REGION)) begin
			if (!found_q && occ_s3 && near_s3) begin
				match_idx_q <= idx_s3;
				match_id_q  <= id_s3;
			end
			if (!free_q && !occ_s3) free_idx_q <= idx_s3;
		end
	end

	// commit decode
	logic                      is_match, is_add;
	cot_pkg::kind_t            kind_d;
	logic [IDX_W-1:0]          slot_d;
	logic [TW-1:0]             oid_d;
	logic                      count_up, count_clr;

	logic [cot_pkg::OFS_W-1:0]        ofs_q;
	logic signed [cot_pkg::NET_W-1:0] net_q;

	assign nid      = now_q + TW'(ofs_q);
	assign is_match = (op_q == cot_pkg::OP_REGION) && found_q;
	assign is_add   = (op_q == cot_pkg::OP_REGION) && !found_q && free_q;

	always_comb begin
		wr_ent    = 1'b0;
		wr_id     = 1'b0;
		wr_idx    = match_idx_q;
		wr_data.x = px_q;
		wr_data.y = py_q;
		wr_data.area      = area_q;
		wr_data.last_seen = now_q;
		kind_d    = cot_pkg::KIND_DROP;
		slot_d    = '0;
		oid_d     = '0;
		count_up  = 1'b0;
		count_clr = 1'b0;
		if (op_q == cot_pkg::OP_SWEEP) begin
			kind_d    = cot_pkg::KIND_FRAME;
			count_clr = cmd.commit;
		end else if (is_match) begin
			kind_d   = cot_pkg::KIND_MATCH;
			slot_d   = match_idx_q;
			oid_d    = match_id_q;
			wr_ent   = cmd.commit;
			count_up = cmd.commit;
		end else if (is_add) begin
			kind_d   = cot_pkg::KIND_ADD;
			slot_d   = free_idx_q;
			oid_d    = nid;
			wr_idx   = free_idx_q;
			wr_data.last_seen = nid;
			wr_ent   = cmd.commit;
			wr_id    = cmd.commit;
			count_up = cmd.commit;
		end
	end

	// occupancy bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			if (remove_s3) occ_q[idx_s3] <= 1'b0;
			if (wr_id) occ_q[wr_idx] <= (nid != '0);
		end
	end

	// per-frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_q <= cot_pkg::OFS_RST;
			net_q <= '0;
		end else if (count_clr) begin
			ofs_q <= cot_pkg::OFS_RST;
			net_q <= '0;
		end else begin
			if (wr_id) ofs_q <= ofs_q + cot_pkg::OFS_W'(1);
			if (count_up && (net_q != cot_pkg::NET_MAX))
				net_q <= net_q + cot_pkg::NET_W'(1);
			else if (remove_s3 && (net_q != cot_pkg::NET_MIN))
				net_q <= net_q - cot_pkg::NET_W'(1);
		end
	end

	// output register
	logic                            m_valid_q;
	logic [cot_pkg::OUT_TDATA_W-1:0] m_data_q;
	logic [1:0]                      m_kind_q;
	logic [cot_pkg::RM_W-1:0]        rm_d;
	logic [cot_pkg::NET_W-1:0]       net_d;

	assign rm_d  = (op_q == cot_pkg::OP_SWEEP) ? removed_q : '0;
	assign net_d = (op_q == cot_pkg::OP_SWEEP) ? net_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_valid_q <= 1'b1;
		end else if (out_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_kind_q <= kind_d;
			m_data_q <= {(cot_pkg::OUT_TDATA_W - cot_pkg::OUT_USED_W)'(0),
				net_d, rm_d, oid_d, cot_pkg::SLOT_W'(slot_d)};
		end
	end

	assign out_valid        = m_valid_q;
	assign out_data         = m_data_q;
	assign out_kind         = m_kind_q;
	assign status.scan_done = tok_s3 && last_s3;
	assign status.out_free  = !m_valid_q || out_ready;

endmodule

// ===== rtl/core/cot_checker.sv =====
// ----------------------------------------------------------------------------
// cot_checker: port-level checks of the tracker
// result beat holding, item pacing and field zeroing per result kind
// ----------------------------------------------------------------------------
module cot_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [cot_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [1:0]                      m_axis_tuser
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed under stall");

	// one item at a time: busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item taken while previous one in flight");

	// match and add carry no frame report
	a_upd: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == cot_pkg::KIND_MATCH ||
			m_axis_tuser == cot_pkg::KIND_ADD) |->
			m_axis_tdata[cot_pkg::OUT_TDATA_W-1:cot_pkg::OUT_RM_LSB] == '0)
		else $error("report fields set on table update");

	// drop and frame end carry no slot or id
	a_rep: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == cot_pkg::KIND_DROP ||
			m_axis_tuser == cot_pkg::KIND_FRAME) |->
			m_axis_tdata[cot_pkg::OUT_RM_LSB-1:0] == '0)
		else $error("slot or id set on drop or frame end");

endmodule

bind centroid_object_tracker_core cot_checker u_cot_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
